// ===== hdl/edfq_pkg.sv =====
// Shared types and constants for the sorted deadline task queue.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps
package edfq_pkg;

   localparam int DEF_CAPACITY = 16;
   localparam int WORD_W = 32;
   localparam int ENTRY_W = 4 * WORD_W;
   localparam int COUNT_W = 5;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_FIND = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   // Which store address a cycle reads.
   typedef enum logic [2:0] {
      RD_NONE,
      RD_K_MINUS1,
      RD_J,
      RD_J_PLUS1,
      RD_ZERO
   } rd_sel_type;

   // Which store address and data a cycle writes.
   typedef enum logic [1:0] {
      WR_NONE,
      WR_NEW_K,
      WR_DATA_K,
      WR_DATA_J
   } wr_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      logic       k_dec;
      logic       j_inc;
      logic       occ_inc;
      logic       occ_dec;
      logic       found_cap;
      logic       st_full;
      logic       st_not_found;
      logic       head_cap;
      logic       head_clr;
   } edfq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] cmd;
      logic       full;
      logic       k_zero;
      logic       j_at_end;
      logic       j_last;
      logic       occ_zero;
      logic       hit;
      logic       shift;
   } edfq_stat_type;

endpackage

// ===== hdl/edf_sorted_task_queue.sv =====
// Earliest-deadline-first task queue kept sorted in a RAM of CAPACITY entries.
// Per command: an insert moves each entry that sorts after the new one up a slot, from the tail,
// then writes the new one (dropped when full); a find scans from slot 0 for the handle; a remove
// scans alike and on a hit shifts later entries down; each then reads slot 0 as the head if any.
// One command at a time, a new one accepted in the result cycle; the receiver cannot stall.
// Synchronous active-high reset empties the queue at once; there is no clearing pass.
`timescale 1ns / 1ps
module edf_sorted_task_queue
   import edfq_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic [WORD_W-1:0]  req_deadline,
   input  logic [WORD_W-1:0]  req_remaining,
   input  logic [WORD_W-1:0]  req_task_handle,
   input  logic [WORD_W-1:0]  req_payload,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [WORD_W-1:0]  rsp_found_deadline,
   output logic [WORD_W-1:0]  rsp_found_remaining,
   output logic [WORD_W-1:0]  rsp_found_payload,
   output logic               rsp_head_valid,
   output logic [WORD_W-1:0]  rsp_head_deadline,
   output logic [WORD_W-1:0]  rsp_head_remaining,
   output logic [WORD_W-1:0]  rsp_head_handle,
   output logic [WORD_W-1:0]  rsp_head_payload,
   output logic [COUNT_W-1:0] rsp_entry_count
);

   edfq_cmd_type  cmd;
   edfq_stat_type stat;
   logic          ctrl_start;

   assign ctrl_start = start;

   edfq_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(ctrl_start),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .stat(stat),
      .cmd(cmd)
   );

   edfq_dp #(
      .CAPACITY(CAPACITY)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .req_cmd(req_cmd),
      .req_deadline(req_deadline),
      .req_remaining(req_remaining),
      .req_task_handle(req_task_handle),
      .req_payload(req_payload),
      .rsp_status(rsp_status),
      .rsp_found_deadline(rsp_found_deadline),
      .rsp_found_remaining(rsp_found_remaining),
      .rsp_found_payload(rsp_found_payload),
      .rsp_head_valid(rsp_head_valid),
      .rsp_head_deadline(rsp_head_deadline),
      .rsp_head_remaining(rsp_head_remaining),
      .rsp_head_handle(rsp_head_handle),
      .rsp_head_payload(rsp_head_payload),
      .rsp_entry_count(rsp_entry_count)
   );

   // An accepted command makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   // The result beat lasts exactly one cycle.
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // An empty queue reports a zero head.
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_head_valid) |-> (rsp_head_deadline == '0 && rsp_head_handle == '0))
      else $error("empty queue reported a nonzero head");

   // A dropped insert never reports found fields.
   a_full_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_found_deadline == '0))
      else $error("dropped insert carried found data");

endmodule

// ===== hdl/edfq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module edfq_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/edfq_ctrl.sv =====
// Sequencer for the task queue: walks the store for insert, search and shift.
// Depends on edfq_pkg for the command and status structs.
`timescale 1ns / 1ps
module edfq_ctrl
   import edfq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   input  edfq_stat_type stat,
   output edfq_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS_CHK,
      S_INS_RD,
      S_INS_EV,
      S_SCN_CHK,
      S_SCN_RD,
      S_SCN_EV,
      S_SHF_CHK,
      S_SHF_RD,
      S_SHF_EV,
      S_HEAD,
      S_HEAD_RD,
      S_HEAD_EV
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   // Next state and per-cycle datapath commands.
   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      cmd = '0;
      cmd.rd_sel = RD_NONE;
      cmd.wr_sel = WR_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.cmd)
               CMD_INSERT: state_in = S_INS_CHK;
               CMD_REMOVE: state_in = S_SCN_CHK;
               CMD_FIND:   state_in = S_SCN_CHK;
               default:    state_in = S_HEAD;
            endcase
         end
         S_INS_CHK: begin
            if (stat.full) begin
               cmd.st_full = 1'b1;
               state_in = S_HEAD;
            end else if (stat.k_zero) begin
               cmd.wr_sel = WR_NEW_K;
               cmd.occ_inc = 1'b1;
               state_in = S_HEAD;
            end else begin
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            cmd.rd_sel = RD_K_MINUS1;
            state_in = S_INS_EV;
         end
         S_INS_EV: begin
            if (stat.shift) begin
               cmd.wr_sel = WR_DATA_K;
               cmd.k_dec = 1'b1;
               state_in = S_INS_CHK;
            end else begin
               cmd.wr_sel = WR_NEW_K;
               cmd.occ_inc = 1'b1;
               state_in = S_HEAD;
            end
         end
         S_SCN_CHK: begin
            if (stat.j_at_end) begin
               cmd.st_not_found = 1'b1;
               state_in = S_HEAD;
            end else begin
               state_in = S_SCN_RD;
            end
         end
         S_SCN_RD: begin
            cmd.rd_sel = RD_J;
            state_in = S_SCN_EV;
         end
         S_SCN_EV: begin
            if (stat.hit) begin
               cmd.found_cap = 1'b1;
               state_in = (stat.cmd == CMD_REMOVE) ? S_SHF_CHK : S_HEAD;
            end else begin
               cmd.j_inc = 1'b1;
               state_in = S_SCN_CHK;
            end
         end
         S_SHF_CHK: begin
            if (stat.j_last) begin
               cmd.occ_dec = 1'b1;
               state_in = S_HEAD;
            end else begin
               state_in = S_SHF_RD;
            end
         end
         S_SHF_RD: begin
            cmd.rd_sel = RD_J_PLUS1;
            state_in = S_SHF_EV;
         end
         S_SHF_EV: begin
            cmd.wr_sel = WR_DATA_J;
            cmd.j_inc = 1'b1;
            state_in = S_SHF_CHK;
         end
         S_HEAD: begin
            if (stat.occ_zero) begin
               cmd.head_clr = 1'b1;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_HEAD_RD;
            end
         end
         S_HEAD_RD: begin
            cmd.rd_sel = RD_ZERO;
            state_in = S_HEAD_EV;
         end
         S_HEAD_EV: begin
            cmd.head_cap = 1'b1;
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and the result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// ===== hdl/edfq_dp.sv =====
// Datapath of the task queue: entry store, walk indexes, count and result registers.
// Depends on edfq_pkg and edfq_ram.
`timescale 1ns / 1ps
module edfq_dp
   import edfq_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                clock,
   input  logic                reset,
   input  edfq_cmd_type        cmd,
   output edfq_stat_type       stat,
   input  logic [1:0]          req_cmd,
   input  logic [WORD_W-1:0]   req_deadline,
   input  logic [WORD_W-1:0]   req_remaining,
   input  logic [WORD_W-1:0]   req_task_handle,
   input  logic [WORD_W-1:0]   req_payload,
   output logic [1:0]          rsp_status,
   output logic [WORD_W-1:0]   rsp_found_deadline,
   output logic [WORD_W-1:0]   rsp_found_remaining,
   output logic [WORD_W-1:0]   rsp_found_payload,
   output logic                rsp_head_valid,
   output logic [WORD_W-1:0]   rsp_head_deadline,
   output logic [WORD_W-1:0]   rsp_head_remaining,
   output logic [WORD_W-1:0]   rsp_head_handle,
   output logic [WORD_W-1:0]   rsp_head_payload,
   output logic [COUNT_W-1:0]  rsp_entry_count
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [1:0]         cmd_ff;
   logic [ENTRY_W-1:0] new_ff;
   logic [IDX_W-1:0]   k_ff;
   logic [CNT_W-1:0]   j_ff;
   logic [CNT_W-1:0]   occ_ff;
   logic [1:0]         status_ff;
   logic [WORD_W-1:0]  f_dl_ff, f_rem_ff, f_pl_ff;
   logic               head_v_ff;
   logic [ENTRY_W-1:0] head_ff;

   logic               wr_en, rd_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic [CNT_W-1:0]   j_next;
   logic [WORD_W-1:0]  e_dl, e_rem, e_hd, e_pl, n_dl, n_rem, n_hd;

   assign j_next = j_ff + 1'b1;
   assign {e_dl, e_rem, e_hd, e_pl} = rd_data;
   assign n_dl = new_ff[4*WORD_W-1:3*WORD_W];
   assign n_rem = new_ff[3*WORD_W-1:2*WORD_W];
   assign n_hd = new_ff[2*WORD_W-1:WORD_W];

   // Store address and data selection.
   always_comb begin
      rd_en = (cmd.rd_sel != RD_NONE);
      case (cmd.rd_sel)
         RD_K_MINUS1: rd_addr = k_ff - 1'b1;
         RD_J:        rd_addr = j_ff[IDX_W-1:0];
         RD_J_PLUS1:  rd_addr = j_next[IDX_W-1:0];
         default:     rd_addr = '0;
      endcase
      wr_en = (cmd.wr_sel != WR_NONE);
      case (cmd.wr_sel)
         WR_NEW_K: begin
            wr_addr = k_ff;
            wr_data = new_ff;
         end
         WR_DATA_K: begin
            wr_addr = k_ff;
            wr_data = rd_data;
         end
         WR_DATA_J: begin
            wr_addr = j_ff[IDX_W-1:0];
            wr_data = rd_data;
         end
         default: begin
            wr_addr = '0;
            wr_data = new_ff;
         end
      endcase
   end

   edfq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Status toward the controller. An entry moves up when it sorts after the new one.
   always_comb begin
      stat.cmd = cmd_ff;
      stat.full = (occ_ff == CNT_W'(CAPACITY));
      stat.k_zero = (k_ff == '0);
      stat.j_at_end = (j_ff == occ_ff);
      stat.j_last = (j_next == occ_ff);
      stat.occ_zero = (occ_ff == '0);
      stat.hit = (e_hd == n_hd);
      stat.shift = (e_dl > n_dl) || ((e_dl == n_dl) && (e_rem > n_rem));
   end

   // Entry count, kept under reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (cmd.occ_inc) begin
         occ_ff <= occ_ff + 1'b1;
      end else if (cmd.occ_dec) begin
         occ_ff <= occ_ff - 1'b1;
      end
   end

   // Command capture, walk indexes and result registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_cmd;
         new_ff <= {req_deadline, req_remaining, req_task_handle, req_payload};
         k_ff <= occ_ff[IDX_W-1:0];
         j_ff <= '0;
         status_ff <= ST_OK;
         f_dl_ff <= '0;
         f_rem_ff <= '0;
         f_pl_ff <= '0;
      end else begin
         if (cmd.k_dec) begin
            k_ff <= k_ff - 1'b1;
         end
         if (cmd.j_inc) begin
            j_ff <= j_next;
         end
         if (cmd.st_full) begin
            status_ff <= ST_FULL;
         end
         if (cmd.st_not_found) begin
            status_ff <= ST_NOT_FOUND;
         end
         if (cmd.found_cap) begin
            f_dl_ff <= e_dl;
            f_rem_ff <= e_rem;
            f_pl_ff <= e_pl;
         end
      end
      if (cmd.head_cap) begin
         head_v_ff <= 1'b1;
         head_ff <= rd_data;
      end else if (cmd.head_clr) begin
         head_v_ff <= 1'b0;
         head_ff <= '0;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_found_deadline = f_dl_ff;
   assign rsp_found_remaining = f_rem_ff;
   assign rsp_found_payload = f_pl_ff;
   assign rsp_head_valid = head_v_ff;
   assign {rsp_head_deadline, rsp_head_remaining, rsp_head_handle, rsp_head_payload} = head_ff;
   assign rsp_entry_count = COUNT_W'(occ_ff);

endmodule

// ===== test/edf_sorted_task_queue_tb.sv =====
// Self-checking testbench for the sorted deadline task queue.
// Depends on edfq_pkg and edf_sorted_task_queue; a local model predicts each response beat.
`timescale 1ns / 1ps
module edf_sorted_task_queue_tb;
   import edfq_pkg::*;

   localparam int CAP = DEF_CAPACITY;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]         status;
      logic [WORD_W-1:0]  f_dl;
      logic [WORD_W-1:0]  f_rem;
      logic [WORD_W-1:0]  f_pl;
      logic               h_valid;
      logic [WORD_W-1:0]  h_dl;
      logic [WORD_W-1:0]  h_rem;
      logic [WORD_W-1:0]  h_handle;
      logic [WORD_W-1:0]  h_pl;
      logic [COUNT_W-1:0] count;
   } queue_reply_type;

   typedef struct packed {
      logic [WORD_W-1:0] dl;
      logic [WORD_W-1:0] rem;
      logic [WORD_W-1:0] handle;
      logic [WORD_W-1:0] pl;
   } task_entry_type;

   // Mirror of the sorted store and the replies it predicts.
   class edf_scoreboard;
      task_entry_type  slots[$];
      queue_reply_type pending[$];
      int              errors;
      int              replies;

      function void note_command(logic [1:0] cmd, logic [WORD_W-1:0] dl,
                                 logic [WORD_W-1:0] rem, logic [WORD_W-1:0] hd,
                                 logic [WORD_W-1:0] pl);
         queue_reply_type r;
         task_entry_type  e;
         int              pos;
         r = '0;
         r.status = ST_OK;
         if (cmd == CMD_INSERT) begin
            if (slots.size() >= CAP) begin
               r.status = ST_FULL;
            end else begin
               // Ties on deadline go by remaining time, then by arrival.
               pos = 0;
               while (pos < slots.size() && (slots[pos].dl < dl ||
                      (slots[pos].dl == dl && slots[pos].rem <= rem)))
                  pos++;
               e.dl = dl;
               e.rem = rem;
               e.handle = hd;
               e.pl = pl;
               slots.insert(pos, e);
            end
         end else if (cmd == CMD_REMOVE || cmd == CMD_FIND) begin
            pos = -1;
            foreach (slots[i])
               if (pos < 0 && slots[i].handle == hd) pos = i;
            if (pos < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               r.f_dl = slots[pos].dl;
               r.f_rem = slots[pos].rem;
               r.f_pl = slots[pos].pl;
               if (cmd == CMD_REMOVE) slots.delete(pos);
            end
         end
         if (slots.size() > 0) begin
            r.h_valid = 1'b1;
            r.h_dl = slots[0].dl;
            r.h_rem = slots[0].rem;
            r.h_handle = slots[0].handle;
            r.h_pl = slots[0].pl;
         end
         r.count = COUNT_W'(slots.size());
         pending.push_back(r);
      endfunction

      function void check_reply(queue_reply_type got);
         queue_reply_type want;
         replies++;
         if (pending.size() == 0) begin
            $error("unexpected response beat");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); errors++;
         end
         if (got.f_dl !== want.f_dl) begin
            $error("found_deadline exp %0h got %0h", want.f_dl, got.f_dl); errors++;
         end
         if (got.f_rem !== want.f_rem) begin
            $error("found_remaining exp %0h got %0h", want.f_rem, got.f_rem); errors++;
         end
         if (got.f_pl !== want.f_pl) begin
            $error("found_payload exp %0h got %0h", want.f_pl, got.f_pl); errors++;
         end
         if (got.h_valid !== want.h_valid) begin
            $error("head_valid exp %0d got %0d", want.h_valid, got.h_valid); errors++;
         end
         if (got.h_dl !== want.h_dl) begin
            $error("head_deadline exp %0h got %0h", want.h_dl, got.h_dl); errors++;
         end
         if (got.h_rem !== want.h_rem) begin
            $error("head_remaining exp %0h got %0h", want.h_rem, got.h_rem); errors++;
         end
         if (got.h_handle !== want.h_handle) begin
            $error("head_handle exp %0h got %0h", want.h_handle, got.h_handle); errors++;
         end
         if (got.h_pl !== want.h_pl) begin
            $error("head_payload exp %0h got %0h", want.h_pl, got.h_pl); errors++;
         end
         if (got.count !== want.count) begin
            $error("entry_count exp %0d got %0d", want.count, got.count); errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_cmd = CMD_QUERY;
   logic [WORD_W-1:0]  req_deadline = '0;
   logic [WORD_W-1:0]  req_remaining = '0;
   logic [WORD_W-1:0]  req_task_handle = '0;
   logic [WORD_W-1:0]  req_payload = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [WORD_W-1:0]  rsp_found_deadline, rsp_found_remaining, rsp_found_payload;
   logic               rsp_head_valid;
   logic [WORD_W-1:0]  rsp_head_deadline, rsp_head_remaining;
   logic [WORD_W-1:0]  rsp_head_handle, rsp_head_payload;
   logic [COUNT_W-1:0] rsp_entry_count;

   edf_scoreboard board = new();
   int  idle_cycles = 0;
   logic [WORD_W-1:0] used_handles[$];
   int  inserts_done = 0;
   int  removes_done = 0;
   int  fulls_seen = 0;

   always #5 clock = ~clock;

   edf_sorted_task_queue dut (.*);

   // Response monitor: each strobed beat is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (rsp_status == ST_FULL) fulls_seen++;
         board.check_reply({rsp_status, rsp_found_deadline, rsp_found_remaining,
                            rsp_found_payload, rsp_head_valid, rsp_head_deadline,
                            rsp_head_remaining, rsp_head_handle, rsp_head_payload,
                            rsp_entry_count});
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Random gap: mostly short, sometimes long, often none. With no gap the
   // start line stays high so the next command follows directly.
   task automatic idle_gap();
      int n;
      n = $urandom_range(0, 9);
      if (n < 4) n = 0;
      else if (n < 9) n = $urandom_range(1, 4);
      else n = $urandom_range(10, 60);
      if (n > 0) start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Present one command beat and hold it until the block takes it.
   task automatic send_command(logic [1:0] cmd, logic [WORD_W-1:0] dl,
                               logic [WORD_W-1:0] rem, logic [WORD_W-1:0] hd,
                               logic [WORD_W-1:0] pl);
      req_cmd <= cmd;
      req_deadline <= dl;
      req_remaining <= rem;
      req_task_handle <= hd;
      req_payload <= pl;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      board.note_command(cmd, dl, rem, hd, pl);
      if (cmd == CMD_INSERT) begin
         used_handles.push_back(hd);
         inserts_done++;
      end
      if (cmd == CMD_REMOVE) removes_done++;
      idle_gap();
   endtask

   // Small value pools make deadline and remaining ties common.
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_handle();
      if (used_handles.size() > 0 && $urandom_range(0, 3) != 0)
         return used_handles[$urandom_range(0, used_handles.size() - 1)];
      return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 40) : $urandom;
   endfunction

   initial begin
      int mode;
      int phase_len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-queue misses, extremes, ties, duplicate handles, then full.
      send_command(CMD_QUERY, '0, '0, '0, '0);
      send_command(CMD_FIND, '0, '0, 32'd5, '0);
      send_command(CMD_REMOVE, '0, '0, 32'd5, '0);
      send_command(CMD_INSERT, '1, '1, '1, '1);
      send_command(CMD_INSERT, '0, '0, '0, '0);
      send_command(CMD_INSERT, 32'd100, 32'd7, 32'd1, 32'haaaa5555);
      send_command(CMD_INSERT, 32'd100, 32'd3, 32'd2, 32'h5555aaaa);
      send_command(CMD_INSERT, 32'd100, 32'd3, 32'd1, 32'h12345678);
      send_command(CMD_FIND, '0, '0, 32'd1, '0);
      send_command(CMD_REMOVE, '0, '0, 32'd1, '0);
      send_command(CMD_REMOVE, '0, '0, 32'd1, '0);
      send_command(CMD_REMOVE, '0, '0, '0, '0);
      send_command(CMD_FIND, '1, '1, '1, '1);
      for (int i = 0; i < CAP; i++)
         send_command(CMD_INSERT, $urandom, $urandom_range(0, 2), i, $urandom);
      send_command(CMD_INSERT, 32'd1, 32'd1, 32'd99, 32'd1);
      send_command(CMD_QUERY, '1, '1, '1, '1);

      // Random: phases lean toward filling or draining so every depth is visited.
      for (int n = 0; n < 420; n++) begin
         if (n % 40 == 0) phase_len = $urandom_range(0, 2);
         mode = $urandom_range(0, 9);
         if (phase_len == 0 ? mode < 6 : phase_len == 1 ? mode < 2 : mode < 4)
            send_command(CMD_INSERT, pick_word(), pick_word(), pick_handle(), $urandom);
         else if (mode < 8)
            send_command(CMD_REMOVE, $urandom, $urandom, pick_handle(), $urandom);
         else if (mode < 9)
            send_command(CMD_FIND, $urandom, $urandom, pick_handle(), $urandom);
         else
            send_command(CMD_QUERY, $urandom, $urandom, $urandom, $urandom);
      end
      start <= 1'b0;

      while (board.pending.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Ran %0d responses: %0d inserts, %0d removes, %0d full drops.",
               board.replies, inserts_done, removes_done, fulls_seen);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
hdl/edfq_pkg.sv
hdl/edfq_ram.sv
hdl/edfq_ctrl.sv
hdl/edfq_dp.sv
hdl/edf_sorted_task_queue.sv
test/edf_sorted_task_queue_tb.sv
